// File: rtl/core/kpe_pkg.sv
// kpe_pkg: word types, op codes and per-key flag update for key_press_edge_table
// no dependencies
package kpe_pkg;

  localparam int KEY_W = 6;

  localparam logic [1:0] OP_DOWN  = 2'd0;
  localparam logic [1:0] OP_UP    = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic             result_kind;
    logic [KEY_W-1:0] key_index;
    logic             held;
    logic             pressed_now;
    logic             released_now;
    logic             last_of_run;
  } out_word_t;

  typedef struct packed {
    logic rnow;
    logic pnow;
    logic rel_prev;
    logic rel;
    logic held_prev;
    logic held;
  } flags_t;

  function automatic flags_t step_flags(flags_t f, logic [1:0] op, logic hit);
    flags_t r;
    logic   pn;
    logic   rn;
    r  = f;
    pn = f.held & ~f.held_prev;
    rn = f.rel & ~f.rel_prev;
    case (op)
      OP_DOWN: begin
        if (hit) begin
          r.held     = 1'b1;
          r.rel_prev = f.rel;
          r.rel      = 1'b0;
        end
      end
      OP_UP: begin
        if (hit) begin
          r.rel_prev = f.rel;
          r.rel      = 1'b1;
        end
      end
      OP_TICK: begin
        r.pnow      = pn;
        r.rnow      = rn;
        r.held      = f.held & ~rn;
        r.held_prev = f.held & ~rn;
        r.rel_prev  = f.rel;
      end
      default: begin
        r = f;
      end
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/kpe_cell.sv
// kpe_cell: one link of the key flag ring, holds the six flags of one key
// depends on kpe_pkg
module kpe_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  kpe_pkg::flags_t d,
  output kpe_pkg::flags_t q
);

  kpe_pkg::flags_t flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (shift) begin
      flags <= d;
    end
  end

  assign q = flags;

endmodule

// File: rtl/core/key_press_edge_table.sv
// key_press_edge_table: per-key press/release edge table built as a rotating ring of cells
// depends on kpe_pkg and kpe_cell
//
//  port     dir  word          handshake
//  cmd      in   in_word_t     taken when start high and busy low
//  result   out  out_word_t    valid for one cycle while strobe high
//
// every command rotates the ring once: a shift for each key, then a closing step,
// so busy stays high through all the shifts and the closing step after a command is taken
// a tick report appears one flagged key later than its key passes the head;
// the final report or a query reply comes in the closing cycle
// reset clears all flags at once; results cannot be stalled
module key_press_edge_table #(
  parameter int NUM_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kpe_pkg::in_word_t  cmd,
  output logic               busy,
  output logic               strobe,
  output kpe_pkg::out_word_t result
);

  localparam int KW = kpe_pkg::KEY_W;
  localparam logic [KW-1:0] LAST_IDX = KW'(NUM_KEYS - 1);

  kpe_pkg::flags_t cell_q [NUM_KEYS];
  kpe_pkg::flags_t head_next;

  logic               shift;
  logic               fin;
  logic [1:0]         op;
  logic [KW-1:0]      key;
  logic [KW-1:0]      idx;
  logic               hit;
  logic               edge_seen;
  logic               pend_vld;
  kpe_pkg::out_word_t pend;
  kpe_pkg::flags_t    qflags;

  assign shift     = busy & ~fin;
  assign hit       = (op == kpe_pkg::OP_TICK) || (idx == key);
  assign head_next = kpe_pkg::step_flags(cell_q[0], op, hit);
  assign edge_seen = (op == kpe_pkg::OP_TICK) && (head_next.pnow || head_next.rnow);

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_ring
    kpe_pkg::flags_t d;
    if (i == NUM_KEYS - 1) begin : g_tail
      assign d = head_next;
    end else begin : g_link
      assign d = cell_q[i+1];
    end
    kpe_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      idx      <= '0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      if (!busy) begin
        strobe <= 1'b0;
        if (start) begin
          busy     <= 1'b1;
          op       <= cmd.op;
          key      <= cmd.key_code;
          idx      <= '0;
          pend_vld <= 1'b0;
          qflags   <= '0;
        end
      end else if (!fin) begin
        strobe <= edge_seen && pend_vld;
        if (op == kpe_pkg::OP_QUERY && idx == key) begin
          qflags <= cell_q[0];
        end
        if (edge_seen) begin
          if (pend_vld) begin
            result <= pend;
          end
          pend_vld          <= 1'b1;
          pend.result_kind  <= kpe_pkg::KIND_REPORT;
          pend.key_index    <= idx;
          pend.held         <= head_next.held;
          pend.pressed_now  <= head_next.pnow;
          pend.released_now <= head_next.rnow;
          pend.last_of_run  <= 1'b0;
        end
        if (idx == LAST_IDX) begin
          idx <= '0;
          fin <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end else begin
        fin    <= 1'b0;
        busy   <= 1'b0;
        strobe <= (op == kpe_pkg::OP_QUERY) || pend_vld;
        if (op == kpe_pkg::OP_QUERY) begin
          result.result_kind  <= kpe_pkg::KIND_REPLY;
          result.key_index    <= key;
          result.held         <= qflags.held;
          result.pressed_now  <= qflags.pnow;
          result.released_now <= qflags.rnow;
          result.last_of_run  <= 1'b1;
        end else if (pend_vld) begin
          result.result_kind  <= pend.result_kind;
          result.key_index    <= pend.key_index;
          result.held         <= pend.held;
          result.pressed_now  <= pend.pressed_now;
          result.released_now <= pend.released_now;
          result.last_of_run  <= 1'b1;
        end
        pend_vld <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result outside a command");
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.result_kind == kpe_pkg::KIND_REPLY) |-> result.last_of_run)
    else $error("query reply not marked last");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (idx == '0 && !fin))
    else $error("ring position not home while idle");
`endif

endmodule
